>>> rtl/dmpw_pkg.sv
// shared types, constants and tables for the dithered mono pixel writer
`default_nettype none

package dmpw_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DITHER_ENABLE    = 2'd0,
    REG_TILE_PATTERN     = 2'd1,
    REG_LINE_PITCH_BYTES = 2'd2,
    REG_MEMORY_WIDTH_PX  = 2'd3
  } cfg_reg_t;

  // configuration register contents
  typedef struct packed {
    logic        dither_enable;
    logic [3:0]  tile_pattern;
    logic [7:0]  line_pitch_bytes;
    logic [10:0] memory_width_px;
  } cfg_t;

  // result field widths
  localparam int INDEX_W = 17;
  localparam int MASK_W  = 8;

  // gray weights for the squared channels, on a 2^16 scale
  localparam logic [15:0] GRAY_WR = 16'd19749;
  localparam logic [15:0] GRAY_WG = 16'd38771;
  localparam logic [15:0] GRAY_WB = 16'd7530;
  localparam int          GRAY_SHIFT = 24;
  localparam logic [9:0]  DITHER_LEVEL = 10'd256;

  // 4x4 ordered dither thresholds
  localparam logic [7:0] BAYER [16] = '{
    8'd8,   8'd136, 8'd40,  8'd168, 8'd200, 8'd72,  8'd232, 8'd104,
    8'd56,  8'd184, 8'd24,  8'd152, 8'd248, 8'd120, 8'd216, 8'd88
  };

endpackage

`default_nettype wire

>>> rtl/dmpw_in_if.sv
// pixel write request channel
`default_nettype none

interface dmpw_in_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic [15:0]           color_rgb565;

  modport source (output valid, output pix_x, output pix_y, output color_rgb565,
                  input ready);
  modport sink   (input valid, input pix_x, input pix_y, input color_rgb565,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/dmpw_out_if.sv
// frame-buffer bit update request channel
`default_nettype none

interface dmpw_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] byte_index;
  logic [7:0]  bit_mask;
  logic        bit_value;

  modport source (output valid, output byte_index, output bit_mask, output bit_value,
                  input ready);
  modport sink   (input valid, input byte_index, input bit_mask, input bit_value,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/dmpw_cfg_regs.sv
// configuration register bank
`default_nettype none

module dmpw_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [dmpw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dmpw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output dmpw_pkg::cfg_t                        cfg
);
  import dmpw_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DITHER_ENABLE:    cfg_nxt.dither_enable    = cfg_wdata[0];
        REG_TILE_PATTERN:     cfg_nxt.tile_pattern     = cfg_wdata[3:0];
        REG_LINE_PITCH_BYTES: cfg_nxt.line_pitch_bytes = cfg_wdata[7:0];
        REG_MEMORY_WIDTH_PX:  cfg_nxt.memory_width_px  = cfg_wdata[10:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dither_enable    <= 1'b0;
      cfg_r.tile_pattern     <= 4'd0;
      cfg_r.line_pitch_bytes <= 8'd1;
      cfg_r.memory_width_px  <= 11'd8;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/dmpw_gray_pipe.sv
// three-stage gray conversion, ordered dither and bit decision
`default_nettype none

module dmpw_gray_pipe (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire dmpw_pkg::cfg_t cfg,
  input  wire logic [1:0]     pix_x_lo,
  input  wire logic [1:0]     pix_y_lo,
  input  wire logic [15:0]    color_rgb565,
  output logic                bit_value
);
  import dmpw_pkg::*;

  logic [4:0] r5;
  logic [5:0] g6;
  logic [4:0] b5;
  logic [7:0] r8;
  logic [7:0] g8;
  logic [7:0] b8;
  logic [3:0] tile_off;
  logic [1:0] thr_row;
  logic [1:0] thr_col;

  // stage 1 registers
  logic [15:0] rsq_r, rsq_nxt;
  logic [15:0] gsq_r, gsq_nxt;
  logic [15:0] bsq_r, bsq_nxt;
  logic [7:0]  thr1_r, thr1_nxt;
  logic        nz1_r, nz1_nxt;
  logic        dith1_r;

  // stage 2 registers
  logic [30:0] pr_r, pr_nxt;
  logic [31:0] pg_r, pg_nxt;
  logic [28:0] pb_r, pb_nxt;
  logic [7:0]  thr2_r;
  logic        nz2_r;
  logic        dith2_r;

  // stage 3 register
  logic [32:0] gray_sum;
  logic [9:0]  level;
  logic        bit_r, bit_nxt;

  // widen to 8 bits per channel, square, look up threshold
  always_comb begin
    r5 = color_rgb565[15:11];
    g6 = color_rgb565[10:5];
    b5 = color_rgb565[4:0];
    r8 = {r5, r5[4:2]};
    g8 = {g6, g6[5:4]};
    b8 = {b5, b5[4:2]};
    rsq_nxt = 16'(r8) * 16'(r8);
    gsq_nxt = 16'(g8) * 16'(g8);
    bsq_nxt = 16'(b8) * 16'(b8);
    tile_off = BAYER[cfg.tile_pattern][7:4];
    thr_row  = pix_y_lo + tile_off[3:2];
    thr_col  = pix_x_lo + tile_off[1:0];
    thr1_nxt = BAYER[{thr_row, thr_col}];
    nz1_nxt  = |color_rgb565;
  end

  // weight each squared channel
  always_comb begin
    pr_nxt = 31'(rsq_r) * 31'(GRAY_WR);
    pg_nxt = 32'(gsq_r) * 32'(GRAY_WG);
    pb_nxt = 29'(bsq_r) * 29'(GRAY_WB);
  end

  // sum, scale down, add threshold, decide
  always_comb begin
    gray_sum = 33'(pr_r) + 33'(pg_r) + 33'(pb_r);
    level    = 10'(gray_sum[32:GRAY_SHIFT]) + 10'(thr2_r);
    bit_nxt  = dith2_r ? (level >= DITHER_LEVEL) : nz2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsq_r   <= rsq_nxt;
      gsq_r   <= gsq_nxt;
      bsq_r   <= bsq_nxt;
      thr1_r  <= thr1_nxt;
      nz1_r   <= nz1_nxt;
      dith1_r <= cfg.dither_enable;
      pr_r    <= pr_nxt;
      pg_r    <= pg_nxt;
      pb_r    <= pb_nxt;
      thr2_r  <= thr1_r;
      nz2_r   <= nz1_r;
      dith2_r <= dith1_r;
      bit_r   <= bit_nxt;
    end
  end

  assign bit_value = bit_r;

endmodule

`default_nettype wire

>>> rtl/dmpw_addr_pipe.sv
// three-stage byte address and bit mask generation
`default_nettype none

module dmpw_addr_pipe #(
  parameter int COORD_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire dmpw_pkg::cfg_t                cfg,
  input  wire logic [COORD_BITS-1:0]         pix_x,
  input  wire logic [COORD_BITS-1:0]         pix_y,
  output logic [dmpw_pkg::INDEX_W-1:0]       byte_index,
  output logic [dmpw_pkg::MASK_W-1:0]        bit_mask
);
  import dmpw_pkg::*;

  localparam int MULT_W = 11;
  localparam int PROD_W = COORD_BITS + MULT_W;
  localparam int ADDR_W = PROD_W + 1;

  logic [MULT_W-1:0] row_mult;

  // stage 1 registers
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [COORD_BITS-1:0] x1_r;
  logic                  dith1_r;

  // stage 2 registers
  logic [ADDR_W-1:0] sum_r, sum_nxt;
  logic [2:0]        xlo2_r;
  logic              dith2_r;

  // stage 3 registers
  logic [INDEX_W-1:0] idx_r, idx_nxt;
  logic [MASK_W-1:0]  mask_r, mask_nxt;

  // row times line length, pitch in dither mode, width in plain mode
  always_comb begin
    row_mult = cfg.dither_enable ? MULT_W'(cfg.line_pitch_bytes) : cfg.memory_width_px;
    prod_nxt = PROD_W'(pix_y) * PROD_W'(row_mult);
  end

  // add the column, in bytes or in pixels
  always_comb begin
    if (dith1_r) begin
      sum_nxt = ADDR_W'(prod_r) + ADDR_W'(x1_r >> 3);
    end else begin
      sum_nxt = ADDR_W'(prod_r) + ADDR_W'(x1_r);
    end
  end

  // pixel addresses drop to bytes, mask from the low column bits
  always_comb begin
    idx_nxt  = dith2_r ? sum_r[INDEX_W-1:0] : sum_r[INDEX_W+2:3];
    mask_nxt = MASK_W'(1) << xlo2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      x1_r    <= pix_x;
      dith1_r <= cfg.dither_enable;
      sum_r   <= sum_nxt;
      xlo2_r  <= x1_r[2:0];
      dith2_r <= dith1_r;
      idx_r   <= idx_nxt;
      mask_r  <= mask_nxt;
    end
  end

  assign byte_index = idx_r;
  assign bit_mask   = mask_r;

endmodule

`default_nettype wire

>>> rtl/dithered_mono_pixel_writer_top.sv
// top level of the dithered mono pixel writer
//
//  port group   dir   handshake        carries
//  in_ch        in    valid / ready    pix_x, pix_y, color_rgb565
//  out_ch       out   valid / ready    byte_index, bit_mask, bit_value
//  cfg_*        in    cfg_we only      cfg_index, cfg_wdata
//
// one request per cycle sustained while out_ch does not stall, out_ch.valid rises when the request reaches stage 3
// three register stages: square / multiply, weight / add, sum / decide
// synchronous active-low reset clears the stage valid bits and loads the register defaults
// a stall on out_ch holds the whole pipeline, in_ch.ready falls with it
`default_nettype none

module dithered_mono_pixel_writer_top #(
  parameter int COORD_BITS = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [dmpw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dmpw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  dmpw_in_if.sink                               in_ch,
  dmpw_out_if.source                            out_ch
);
  import dmpw_pkg::*;

  cfg_t cfg;
  logic advance;
  logic v1_r, v2_r, v3_r;

  // configuration registers
  dmpw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // pipeline moves unless a finished request is held at the output
  assign advance     = !v3_r || out_ch.ready;
  assign in_ch.ready = advance;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // bit value datapath
  dmpw_gray_pipe u_gray (
    .clk          (clk),
    .en           (advance),
    .cfg          (cfg),
    .pix_x_lo     (in_ch.pix_x[1:0]),
    .pix_y_lo     (in_ch.pix_y[1:0]),
    .color_rgb565 (in_ch.color_rgb565),
    .bit_value    (out_ch.bit_value)
  );

  // address and mask datapath
  dmpw_addr_pipe #(
    .COORD_BITS (COORD_BITS)
  ) u_addr (
    .clk        (clk),
    .en         (advance),
    .cfg        (cfg),
    .pix_x      (in_ch.pix_x),
    .pix_y      (in_ch.pix_y),
    .byte_index (out_ch.byte_index),
    .bit_mask   (out_ch.bit_mask)
  );

  assign out_ch.valid = v3_r;

endmodule

`default_nettype wire

>>> tb/dmpw_update_checker.sv
// checker for the dithered mono pixel writer: predicts every bit update and compares
`timescale 1ns / 100ps

module dmpw_update_checker #(
  parameter int COORD_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dmpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmpw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  dmpw_in_if                              in_ch,
  dmpw_out_if                             out_ch,
  output int                              fail_count,
  output int                              backlog
);
  import dmpw_pkg::*;

  // one frame-buffer bit update
  typedef struct packed {
    logic [16:0] byte_index;
    logic [7:0]  bit_mask;
    logic        bit_value;
  } bit_update_t;

  // luma weights for the squared channels, 2^16 scale
  localparam logic [39:0] LUMA_R = 40'd19749;
  localparam logic [39:0] LUMA_G = 40'd38771;
  localparam logic [39:0] LUMA_B = 40'd7530;

  // ordered dither thresholds, entry 0 in the low byte
  localparam logic [127:0] THRESH_TABLE = {
    8'd88,  8'd216, 8'd120, 8'd248, 8'd152, 8'd24, 8'd184, 8'd56,
    8'd104, 8'd232, 8'd72,  8'd200, 8'd168, 8'd40, 8'd136, 8'd8
  };

  cfg_t        shadow_cfg;
  bit_update_t expected_updates[$];
  int          errors = 0;

  assign fail_count = errors;

  function automatic logic [7:0] thresh_at(logic [3:0] i);
    return THRESH_TABLE[i*8 +: 8];
  endfunction

  // widen to 8 bits per channel, weight the squares, keep the integer part
  function automatic logic [7:0] gray_level(logic [15:0] c);
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [39:0] acc;
    r8 = {c[15:11], c[15:13]};
    g8 = {c[10:5], c[10:9]};
    b8 = {c[4:0], c[4:2]};
    acc = r8 * r8 * LUMA_R + g8 * g8 * LUMA_G + b8 * b8 * LUMA_B;
    return acc[31:24];
  endfunction

  function automatic bit_update_t predict_bit_update(cfg_t cfg, logic [COORD_BITS-1:0] px,
                                                     logic [COORD_BITS-1:0] py,
                                                     logic [15:0] color);
    bit_update_t u;
    logic [3:0]  off;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [8:0]  level;
    logic [31:0] addr;
    logic [31:0] x32;
    logic [31:0] y32;
    x32 = 32'(px);
    y32 = 32'(py);
    if (cfg.dither_enable) begin
      off   = 4'(thresh_at(cfg.tile_pattern) >> 4);
      row   = py[1:0] + off[3:2];
      col   = px[1:0] + off[1:0];
      level = {1'b0, gray_level(color)} + {1'b0, thresh_at({row, col})};
      u.bit_value = level[8];
      addr = y32 * 32'(cfg.line_pitch_bytes) + (x32 >> 3);
    end else begin
      u.bit_value = (color != 16'd0);
      addr = (y32 * 32'(cfg.memory_width_px) + x32) >> 3;
    end
    u.byte_index = addr[16:0];
    u.bit_mask   = 8'(1) << px[2:0];
    return u;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // register shadow
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_cfg <= '{dither_enable: 1'b0, tile_pattern: 4'd0,
                      line_pitch_bytes: 8'd1, memory_width_px: 11'd8};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DITHER_ENABLE:    shadow_cfg.dither_enable    <= cfg_wdata[0];
        REG_TILE_PATTERN:     shadow_cfg.tile_pattern     <= cfg_wdata[3:0];
        REG_LINE_PITCH_BYTES: shadow_cfg.line_pitch_bytes <= cfg_wdata[7:0];
        REG_MEMORY_WIDTH_PX:  shadow_cfg.memory_width_px  <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // compare each result with the oldest prediction, then queue new requests
  always @(posedge clk) begin
    bit_update_t want;
    if (!rst_n) begin
      expected_updates.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_updates.size() == 0) begin
          report_mismatch($sformatf("result with none pending idx=%0h mask=%0h val=%0b",
                                    out_ch.byte_index, out_ch.bit_mask, out_ch.bit_value));
        end else begin
          want = expected_updates.pop_front();
          if (out_ch.byte_index !== want.byte_index)
            report_mismatch($sformatf("byte_index got %0h want %0h",
                                      out_ch.byte_index, want.byte_index));
          if (out_ch.bit_mask !== want.bit_mask)
            report_mismatch($sformatf("bit_mask got %0h want %0h",
                                      out_ch.bit_mask, want.bit_mask));
          if (out_ch.bit_value !== want.bit_value)
            report_mismatch($sformatf("bit_value got %0b want %0b",
                                      out_ch.bit_value, want.bit_value));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_updates.push_back(predict_bit_update(shadow_cfg, in_ch.pix_x, in_ch.pix_y,
                                                      in_ch.color_rgb565));
    end
    backlog <= expected_updates.size();
  end

endmodule

>>> tb/tb_dithered_mono_pixel_writer_top.sv
// testbench top: pixel write stimulus, register setup and verdict
`timescale 1ns / 100ps

module tb_dithered_mono_pixel_writer_top;
  import dmpw_pkg::*;

  localparam int COORD_BITS = 10;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 53;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  cfg_reg_t   cfg_index;
  logic [10:0] cfg_wdata;
  int         fail_count;
  int         backlog;
  int         cycle_count = 0;
  bit         calm = 1'b0;

  dmpw_in_if #(.COORD_BITS(COORD_BITS)) in_ch ();
  dmpw_out_if out_ch ();

  dithered_mono_pixel_writer_top #(.COORD_BITS(COORD_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  dmpw_update_checker #(.COORD_BITS(COORD_BITS)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // sender gap: mostly none, sometimes short, rarely long
  function automatic int send_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // receiver stall length, never zero
  function automatic int stall_len();
    if ($urandom_range(0, 99) < 82) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random result-side backpressure
  initial begin
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!calm) begin
        out_ch.ready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end
    end
  end

  // one pixel write request, returns at the edge that accepts it
  task automatic write_pixel(logic [9:0] px, logic [9:0] py, logic [15:0] color);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.pix_x        <= px;
    in_ch.pix_y        <= py;
    in_ch.color_rgb565 <= color;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop sending and wait until every bit update has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t r, logic [10:0] d);
    cfg_index <= r;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  // write all four registers back to back
  task automatic program_regs(logic [10:0] de, logic [10:0] tp, logic [10:0] pitch,
                              logic [10:0] width);
    cfg_we <= 1'b1;
    put_reg(REG_DITHER_ENABLE, de);
    put_reg(REG_TILE_PATTERN, tp);
    put_reg(REG_LINE_PITCH_BYTES, pitch);
    put_reg(REG_MEMORY_WIDTH_PX, width);
    cfg_we <= 1'b0;
  endtask

  // random settings, extremes weighted in, upper data bits left as noise
  task automatic program_random(int phase);
    logic [10:0] de;
    logic [10:0] tp;
    logic [10:0] pitch;
    logic [10:0] width;
    de    = 11'($urandom);
    tp    = 11'($urandom);
    pitch = 11'($urandom);
    width = 11'($urandom);
    de[0] = phase[0];
    case ($urandom_range(0, 4))
      0: pitch[7:0] = 8'd0;
      1: pitch[7:0] = 8'd1;
      2: pitch[7:0] = 8'd128;
      3: pitch[7:0] = 8'd255;
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0: width = 11'd0;
      1: width = 11'd1;
      2: width = 11'd2047;
      3: width = 11'd1024;
      default: ;
    endcase
    program_regs(de, tp, pitch, width);
  endtask

  function automatic logic [9:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_color();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h0001 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus and verdict
  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_DITHER_ENABLE;
    cfg_wdata          <= 11'd0;
    in_ch.valid        <= 1'b0;
    in_ch.pix_x        <= '0;
    in_ch.pix_y        <= '0;
    in_ch.color_rgb565 <= 16'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: plain mode, 8 pixels per line
    write_pixel(10'd0, 10'd0, 16'h0000);
    write_pixel(10'd1023, 10'd1023, 16'hffff);
    write_pixel(10'd7, 10'd0, 16'h0001);
    write_pixel(10'd5, 10'd3, 16'h8000);
    settle();

    // dither, last tile pattern, widest pitch: walk the threshold cells
    program_regs(11'd1, 11'd15, 11'd255, 11'd2047);
    write_pixel(10'd0, 10'd0, 16'h8410);
    write_pixel(10'd1, 10'd0, 16'h8410);
    write_pixel(10'd2, 10'd0, 16'h8410);
    write_pixel(10'd3, 10'd0, 16'h8410);
    write_pixel(10'd0, 10'd1, 16'h8410);
    write_pixel(10'd1, 10'd2, 16'h8410);
    write_pixel(10'd2, 10'd3, 16'h8410);
    write_pixel(10'd3, 10'd3, 16'h8410);
    // address past 17 bits wraps
    write_pixel(10'd1023, 10'd1023, 16'hffff);
    settle();

    // plain mode, widest line, wrap and a lone green bit
    program_regs(11'd0, 11'd0, 11'd0, 11'd2047);
    write_pixel(10'd1023, 10'd1023, 16'hffff);
    write_pixel(10'd5, 10'd900, 16'h0020);
    settle();

    // zero pitch in dither mode: row adds nothing
    program_regs(11'd1, 11'd7, 11'd0, 11'd0);
    write_pixel(10'd9, 10'd700, 16'h1234);
    write_pixel(10'd1022, 10'd511, 16'h0000);
    settle();

    // zero width in plain mode
    program_regs(11'd0, 11'd0, 11'd1, 11'd0);
    write_pixel(10'd17, 10'd500, 16'h0800);
    settle();

    // random phases, every fourth one without idling
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      calm = (phase % 4 == 3);
      program_random(phase);
      for (int n = 0; n < PHASE_ITEMS; n++)
        write_pixel(rand_coord(), rand_coord(), rand_color());
      settle();
    end
    calm = 1'b0;

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
